FILE: hdl/hpss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heat plate stencil sweep.
// No dependencies; every other file imports this package.
package hpss_pkg;

   localparam int ROW_W  = 13;
   localparam int COL_W  = 13;
   localparam int SIZE_W = 14;
   localparam int VAL_W  = 16;
   localparam int IDX_W  = 3;

   localparam int MAX_SIZE = 8192;
   localparam int MIN_SIZE = 3;

   localparam logic [SIZE_W-1:0] RST_ROWS       = 14'd8192;
   localparam logic [SIZE_W-1:0] RST_COLS       = 14'd5768;
   localparam logic [ROW_W-1:0]  RST_POINT_ROW  = 13'd200;
   localparam logic [COL_W-1:0]  RST_POINT_COL  = 13'd500;
   localparam logic [ROW_W-1:0]  RST_FIXED_ROW  = 13'd400;
   localparam logic [SIZE_W-1:0] RST_SPAN_BEGIN = 14'd0;
   localparam logic [SIZE_W-1:0] RST_SPAN_END   = 14'd330;
   localparam logic [VAL_W-1:0]  RST_HOT_VALUE  = 16'd25600;

   typedef enum logic [IDX_W-1:0] {
      REG_ROWS,
      REG_COLS,
      REG_POINT_ROW,
      REG_POINT_COL,
      REG_FIXED_ROW,
      REG_SPAN_BEGIN,
      REG_SPAN_END,
      REG_HOT_VALUE
   } reg_idx_type;

   // Clamped sizes and hot-cell settings
   typedef struct packed {
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic [ROW_W-1:0]  point_row;
      logic [COL_W-1:0]  point_col;
      logic [ROW_W-1:0]  fixed_row;
      logic [SIZE_W-1:0] span_begin;
      logic [SIZE_W-1:0] span_end;
      logic [VAL_W-1:0]  hot_value;
   } cfg_type;

   // Position and flags of a request between read issue and write back
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             first_row;
      logic             right_ok;
      logic             last_row;
      logic             last_col;
      logic             clear_pre;
      logic             clear_post;
   } stage_type;

   typedef struct packed {
      logic [VAL_W-1:0] new_value;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             last_of_frame;
      logic [VAL_W-1:0] max_residual;
   } res_type;

   typedef struct packed {
      logic    go;
      logic    valid0;
      res_type res0;
      logic    valid1;
      res_type res1;
   } push_type;

endpackage

FILE: hdl/hpss_req_if.sv
`timescale 1ns / 1ps
// Request channel: one old plate temperature per transfer.
// Depends on hpss_pkg.
interface hpss_req_if
   import hpss_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

FILE: hdl/hpss_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one new cell temperature with its position.
// Depends on hpss_pkg.
interface hpss_rsp_if
   import hpss_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] new_value;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic             last_of_frame;
   logic [VAL_W-1:0] max_residual;

   modport source (output valid, output new_value, output out_row, output out_col,
                   output last_of_frame, output max_residual, input ready);
   modport sink (input valid, input new_value, input out_row, input out_col,
                 input last_of_frame, input max_residual, output ready);
endinterface

FILE: hdl/hpss_csr_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on hpss_pkg.
interface hpss_csr_if
   import hpss_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [VAL_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/heat_plate_stencil_sweep.sv
`timescale 1ns / 1ps
// Top level of the Jacobi five-point stencil sweep.
// Depends on hpss_pkg, the channel interfaces, hpss_regs, hpss_sweep and hpss_out_buf.
//
//   channel  dir  payload                                        transfer
//   req_if   in   cell_value                                     valid && ready
//   rsp_if   out  new_value out_row out_col last_of_frame         valid && ready
//                 max_residual
//   csr_if   in   index data                                     valid && ready
//
// One request per cycle while the response buffer has room; a request on the last row
// gives two responses, so that row runs slower, limited by the single response port.
// A request passes the line store read stage, then the response buffer, before its
// response is valid. A stalled response holds the read stage, then the input.
// Reset is synchronous and clears counters, residual and buffers; the
// line store is not cleared and is filled by the first two rows of each sweep.
module heat_plate_stencil_sweep
   import hpss_pkg::*;
#(
   parameter int MAX_COLS  = 8192,
   parameter int TEMP_BITS = 16
)(
   input  logic       clock,
   input  logic       reset,
   hpss_req_if.sink   req_if,
   hpss_rsp_if.source rsp_if,
   hpss_csr_if.sink   csr_if
);

   cfg_type  cfg;
   push_type push;
   logic     buf_free;

   hpss_regs #(
      .MAX_COLS (MAX_COLS)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   hpss_sweep #(
      .MAX_COLS  (MAX_COLS),
      .TEMP_BITS (TEMP_BITS)
   ) u_sweep (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_value (req_if.cell_value),
      .buf_free (buf_free),
      .push     (push)
   );

   hpss_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .buf_free (buf_free),
      .rsp_if   (rsp_if)
   );

endmodule

FILE: hdl/hpss_regs.sv
`timescale 1ns / 1ps
// Configuration registers with size clamping.
// Depends on hpss_pkg and hpss_csr_if.
module hpss_regs
   import hpss_pkg::*;
#(
   parameter int MAX_COLS = 8192
)(
   input  logic          clock,
   input  logic          reset,
   hpss_csr_if.sink      csr_if,
   output cfg_type       cfg
);

   localparam int COL_LIM = (MAX_COLS < MAX_SIZE) ? MAX_COLS : MAX_SIZE;
   localparam logic [SIZE_W-1:0] COL_MAX = SIZE_W'(COL_LIM);
   localparam logic [SIZE_W-1:0] ROW_MAX = SIZE_W'(MAX_SIZE);
   localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(MIN_SIZE);

   logic [SIZE_W-1:0] rows_ff, cols_ff, span_begin_ff, span_end_ff;
   logic [ROW_W-1:0]  point_row_ff, fixed_row_ff;
   logic [COL_W-1:0]  point_col_ff;
   logic [VAL_W-1:0]  hot_value_ff;
   logic              wr_en;

   assign csr_if.ready = !reset;
   assign wr_en        = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= RST_ROWS;
         cols_ff       <= RST_COLS;
         point_row_ff  <= RST_POINT_ROW;
         point_col_ff  <= RST_POINT_COL;
         fixed_row_ff  <= RST_FIXED_ROW;
         span_begin_ff <= RST_SPAN_BEGIN;
         span_end_ff   <= RST_SPAN_END;
         hot_value_ff  <= RST_HOT_VALUE;
      end else if (wr_en) begin
         case (reg_idx_type'(csr_if.index))
            REG_ROWS:       rows_ff       <= csr_if.data[SIZE_W-1:0];
            REG_COLS:       cols_ff       <= csr_if.data[SIZE_W-1:0];
            REG_POINT_ROW:  point_row_ff  <= csr_if.data[ROW_W-1:0];
            REG_POINT_COL:  point_col_ff  <= csr_if.data[COL_W-1:0];
            REG_FIXED_ROW:  fixed_row_ff  <= csr_if.data[ROW_W-1:0];
            REG_SPAN_BEGIN: span_begin_ff <= csr_if.data[SIZE_W-1:0];
            REG_SPAN_END:   span_end_ff   <= csr_if.data[SIZE_W-1:0];
            REG_HOT_VALUE:  hot_value_ff  <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.rows = (rows_ff < SIZE_MIN) ? SIZE_MIN : (rows_ff > ROW_MAX) ? ROW_MAX : rows_ff;
      cfg.cols = (cols_ff < SIZE_MIN) ? SIZE_MIN : (cols_ff > COL_MAX) ? COL_MAX : cols_ff;
      cfg.point_row  = point_row_ff;
      cfg.point_col  = point_col_ff;
      cfg.fixed_row  = fixed_row_ff;
      cfg.span_begin = span_begin_ff;
      cfg.span_end   = span_end_ff;
      cfg.hot_value  = hot_value_ff;
   end

endmodule

FILE: hdl/hpss_sweep.sv
`timescale 1ns / 1ps
// Row/column counters, line store memory and five-point stencil datapath.
// Depends on hpss_pkg.
module hpss_sweep
   import hpss_pkg::*;
#(
   parameter int MAX_COLS  = 8192,
   parameter int TEMP_BITS = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [VAL_W-1:0] in_value,
   input  logic             buf_free,
   output push_type         push
);

   localparam int DEPTH = (MAX_COLS < MAX_SIZE) ? MAX_COLS : MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = (TEMP_BITS < VAL_W) ? TEMP_BITS : VAL_W;

   // Each entry: upper half is row r-2, lower half is row r-1
   logic [2*TW-1:0] line_mem [DEPTH];
   logic [2*TW-1:0] rd_a_ff, rd_b_ff;

   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic             b_valid_ff, b_valid_in;
   stage_type        b_ctl_ff, b_ctl_in;
   logic [TW-1:0]    b_x_ff;
   logic [TW-1:0]    left_ff, left_in;
   logic [VAL_W-1:0] worst_ff, worst_in;

   logic              accept, b_adv;
   logic              col_wrap, row_over, col_end, row_last;
   logic [SIZE_W-1:0] row_pre, row_next, col_next;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;

   logic [TW-1:0]     centre, up, right, down;
   logic [TW+1:0]     nsum, four, diff;
   logic [TW+2:0]     total;
   logic [VAL_W-1:0]  avg, res, worst_base, worst_upd;
   logic [ROW_W-1:0]  up_row;
   logic              fixed_up, fixed_cur, edge_cell, interior;

   function automatic logic cell_fixed(cfg_type c, logic [ROW_W-1:0] r,
                                       logic [COL_W-1:0] k);
      logic [SIZE_W-1:0] kw;
      kw = {1'b0, k};
      return (r == c.point_row && k == c.point_col) ||
             (r == c.fixed_row && kw >= c.span_begin && kw < c.span_end);
   endfunction

   // Request intake: position, wrap flags and read issue
   always_comb begin
      accept   = in_valid && in_ready;
      col_wrap = {1'b0, col_count_ff} >= cfg.cols;
      row_pre  = {1'b0, row_count_ff} + SIZE_W'(col_wrap);
      row_over = row_pre >= cfg.rows;
      cur_row  = row_over ? '0 : row_pre[ROW_W-1:0];
      cur_col  = col_wrap ? '0 : col_count_ff;
      col_next = {1'b0, cur_col} + SIZE_W'(1);
      row_next = {1'b0, cur_row} + SIZE_W'(1);
      col_end  = col_next >= cfg.cols;
      row_last = row_next == cfg.rows;

      b_ctl_in.row        = cur_row;
      b_ctl_in.col        = cur_col;
      b_ctl_in.first_row  = cur_row == '0;
      b_ctl_in.right_ok   = !col_end;
      b_ctl_in.last_row   = row_last;
      b_ctl_in.last_col   = col_end;
      b_ctl_in.clear_pre  = row_over;
      b_ctl_in.clear_post = col_end && row_last;

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         col_count_in = col_end ? '0 : col_next[COL_W-1:0];
         row_count_in = col_end ? (row_last ? '0 : row_next[ROW_W-1:0]) : cur_row;
      end
   end

   // Stencil and residual on the stage holding the read data
   always_comb begin
      b_adv    = b_valid_ff && buf_free;
      in_ready = !reset && (!b_valid_ff || b_adv);

      centre = rd_a_ff[TW-1:0];
      up     = rd_a_ff[2*TW-1:TW];
      right  = b_ctl_ff.right_ok ? rd_b_ff[TW-1:0] : '0;
      down   = b_x_ff;

      nsum  = (TW+2)'(up) + (TW+2)'(down) + (TW+2)'(left_ff) + (TW+2)'(right);
      four  = {centre, 2'b00};
      total = (TW+3)'(four) + (TW+3)'(nsum);
      avg   = VAL_W'(total[TW+2:3]);
      diff  = four - nsum;
      res   = VAL_W'(diff[TW+1:2]);

      up_row    = b_ctl_ff.row - ROW_W'(1);
      fixed_up  = cell_fixed(cfg, up_row, b_ctl_ff.col);
      fixed_cur = cell_fixed(cfg, b_ctl_ff.row, b_ctl_ff.col);
      edge_cell = (b_ctl_ff.row == ROW_W'(1)) || (b_ctl_ff.col == '0) || b_ctl_ff.last_col;
      interior  = !b_ctl_ff.first_row && !fixed_up && !edge_cell;

      worst_base = b_ctl_ff.clear_pre ? '0 : worst_ff;
      worst_upd  = (interior && (four > nsum) && (res > worst_base)) ? res : worst_base;

      push.go                   = b_adv;
      push.valid0               = !b_ctl_ff.first_row;
      push.res0.new_value       = fixed_up ? cfg.hot_value : (edge_cell ? '0 : avg);
      push.res0.out_row         = up_row;
      push.res0.out_col         = b_ctl_ff.col;
      push.res0.last_of_frame   = 1'b0;
      push.res0.max_residual    = '0;
      push.valid1               = b_ctl_ff.last_row;
      push.res1.new_value       = fixed_cur ? cfg.hot_value : '0;
      push.res1.out_row         = b_ctl_ff.row;
      push.res1.out_col         = b_ctl_ff.col;
      push.res1.last_of_frame   = b_ctl_ff.last_col;
      push.res1.max_residual    = b_ctl_ff.last_col ? worst_upd : '0;

      b_valid_in = accept || (b_valid_ff && !b_adv);
      worst_in   = worst_ff;
      left_in    = left_ff;
      if (b_adv) begin
         worst_in = b_ctl_ff.clear_post ? '0 : worst_upd;
         left_in  = centre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
         b_valid_ff   <= 1'b0;
         worst_ff     <= '0;
         left_ff      <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         b_valid_ff   <= b_valid_in;
         worst_ff     <= worst_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff <= b_ctl_in;
         b_x_ff   <= in_value[TW-1:0];
      end
   end

   // Line store: two reads at intake, write back when the stage retires
   always_ff @(posedge clock) begin
      if (b_adv) begin
         line_mem[b_ctl_ff.col[AW-1:0]] <= {centre, b_x_ff};
      end
      if (accept) begin
         rd_a_ff <= line_mem[cur_col[AW-1:0]];
         rd_b_ff <= line_mem[col_next[AW-1:0]];
      end
   end

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted request did not reach the read stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |=> (b_valid_ff && $stable(b_ctl_ff)))
      else $error("stalled read stage changed");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (b_adv && b_ctl_ff.clear_post) |=> (worst_ff == '0))
      else $error("residual not cleared at end of sweep");

endmodule

FILE: hdl/hpss_out_buf.sv
`timescale 1ns / 1ps
// Two-entry response buffer; takes zero, one or two results per request.
// Depends on hpss_pkg and hpss_rsp_if.
module hpss_out_buf
   import hpss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        buf_free,
   hpss_rsp_if.source  rsp_if
);

   logic [1:0] cnt_ff, cnt_in;
   res_type    q0_ff, q0_in, q1_ff, q1_in;
   logic       pop;

   always_comb begin
      pop      = (cnt_ff != 2'd0) && rsp_if.ready;
      buf_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_if.ready);

      cnt_in = cnt_ff;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      if (push.go && (push.valid0 || push.valid1)) begin
         q0_in  = push.valid0 ? push.res0 : push.res1;
         q1_in  = push.res1;
         cnt_in = (push.valid0 && push.valid1) ? 2'd2 : 2'd1;
      end else if (pop) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_if.valid         = cnt_ff != 2'd0;
   assign rsp_if.new_value     = q0_ff.new_value;
   assign rsp_if.out_row       = q0_ff.out_row;
   assign rsp_if.out_col       = q0_ff.out_col;
   assign rsp_if.last_of_frame = q0_ff.last_of_frame;
   assign rsp_if.max_residual  = q0_ff.max_residual;

   a_pair_loads: assert property (@(posedge clock) disable iff (reset)
      (push.go && push.valid0 && push.valid1) |=> (cnt_ff == 2'd2))
      else $error("result pair not held in buffer");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push.go && (push.valid0 || push.valid1)) |-> buf_free)
      else $error("results pushed into a full buffer");

endmodule

FILE: test/hpss_sweep_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the heat plate stencil sweep: watches the request, response and
// configuration channels, predicts every response and compares it field by field.
// Depends on hpss_pkg and the three channel interfaces.
module hpss_sweep_checker
   import hpss_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hpss_req_if  req_mon,
   hpss_rsp_if  rsp_mon,
   hpss_csr_if  csr_mon,
   output int   fail_count,
   output int   pending,
   output int   rsp_count,
   output int   sweep_count
);

   logic [SIZE_W-1:0] rows_cfg, cols_cfg, span_begin_cfg, span_end_cfg;
   logic [ROW_W-1:0]  point_row_cfg, fixed_row_cfg;
   logic [COL_W-1:0]  point_col_cfg;
   logic [VAL_W-1:0]  hot_cfg;

   bit [VAL_W-1:0] row_above [MAX_SIZE];
   bit [VAL_W-1:0] row_prev [MAX_SIZE];
   bit [VAL_W-1:0] left_tap;
   bit [VAL_W-1:0] peak_residual;
   int unsigned    row_pos, col_pos;
   res_type        cell_queue [$];

   function automatic int unsigned plate_rows();
      if (rows_cfg < MIN_SIZE) return MIN_SIZE;
      if (rows_cfg > MAX_SIZE) return MAX_SIZE;
      return rows_cfg;
   endfunction

   function automatic int unsigned plate_cols();
      if (cols_cfg < MIN_SIZE) return MIN_SIZE;
      if (cols_cfg > MAX_SIZE) return MAX_SIZE;
      return cols_cfg;
   endfunction

   function automatic logic is_hot(input int unsigned r, input int unsigned c);
      return (r == point_row_cfg && c == point_col_cfg) ||
             (r == fixed_row_cfg && c >= span_begin_cfg && c < span_end_cfg);
   endfunction

   function automatic res_type make_cell(input logic [VAL_W-1:0] v, input int unsigned r,
                                         input int unsigned c, input logic last,
                                         input logic [VAL_W-1:0] resid);
      res_type rec;
      rec.new_value     = v;
      rec.out_row       = ROW_W'(r);
      rec.out_col       = COL_W'(c);
      rec.last_of_frame = last;
      rec.max_residual  = resid;
      return rec;
   endfunction

   // Take one old temperature, queue the new cells it completes.
   task automatic predict_cell(input logic [VAL_W-1:0] x);
      int unsigned nrows, ncols, r, c, orow;
      int unsigned centre, north, south, west, east, ring, four, resid;
      logic [VAL_W-1:0] val;
      logic last;
      nrows = plate_rows();
      ncols = plate_cols();
      if (col_pos >= ncols) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= nrows) begin
         row_pos = 0;
         peak_residual = '0;
      end
      r = row_pos;
      c = col_pos;
      if (r >= 1) begin
         orow   = r - 1;
         centre = row_prev[c];
         north  = row_above[c];
         west   = left_tap;
         east   = (c + 1 < ncols) ? row_prev[c + 1] : 0;
         south  = x;
         if (is_hot(orow, c)) begin
            val = hot_cfg;
         end else if (orow == 0 || orow == nrows - 1 || c == 0 || c == ncols - 1) begin
            val = '0;
         end else begin
            ring = north + south + west + east;
            four = centre << 2;
            val  = VAL_W'((four + ring) >> 3);
            if (four > ring) begin
               resid = (four - ring) >> 2;
               if (resid > peak_residual) peak_residual = VAL_W'(resid);
            end
         end
         cell_queue.push_back(make_cell(val, orow, c, 1'b0, '0));
      end
      left_tap     = row_prev[c];
      row_above[c] = row_prev[c];
      row_prev[c]  = x;
      if (r == nrows - 1) begin
         last = (c == ncols - 1);
         cell_queue.push_back(make_cell(is_hot(r, c) ? hot_cfg : '0, r, c, last,
                                        last ? peak_residual : '0));
      end
      col_pos++;
      if (col_pos >= ncols) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= nrows) begin
            row_pos = 0;
            peak_residual = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         rows_cfg       = RST_ROWS;
         cols_cfg       = RST_COLS;
         point_row_cfg  = RST_POINT_ROW;
         point_col_cfg  = RST_POINT_COL;
         fixed_row_cfg  = RST_FIXED_ROW;
         span_begin_cfg = RST_SPAN_BEGIN;
         span_end_cfg   = RST_SPAN_END;
         hot_cfg        = RST_HOT_VALUE;
         row_pos        = 0;
         col_pos        = 0;
         left_tap       = '0;
         peak_residual  = '0;
         cell_queue.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (reg_idx_type'(csr_mon.index))
               REG_ROWS:       rows_cfg       = csr_mon.data[SIZE_W-1:0];
               REG_COLS:       cols_cfg       = csr_mon.data[SIZE_W-1:0];
               REG_POINT_ROW:  point_row_cfg  = csr_mon.data[ROW_W-1:0];
               REG_POINT_COL:  point_col_cfg  = csr_mon.data[COL_W-1:0];
               REG_FIXED_ROW:  fixed_row_cfg  = csr_mon.data[ROW_W-1:0];
               REG_SPAN_BEGIN: span_begin_cfg = csr_mon.data[SIZE_W-1:0];
               REG_SPAN_END:   span_end_cfg   = csr_mon.data[SIZE_W-1:0];
               REG_HOT_VALUE:  hot_cfg        = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_cell(req_mon.cell_value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_count++;
            if (rsp_mon.last_of_frame) sweep_count++;
            if (cell_queue.size() == 0) begin
               $error("response at (%0d,%0d) with no request pending",
                      rsp_mon.out_row, rsp_mon.out_col);
               fail_count++;
            end else begin
               want = cell_queue.pop_front();
               if (rsp_mon.new_value !== want.new_value) begin
                  $error("new_value at (%0d,%0d): expected %0d, got %0d", want.out_row,
                         want.out_col, want.new_value, rsp_mon.new_value);
                  fail_count++;
               end
               if (rsp_mon.out_row !== want.out_row) begin
                  $error("out_row: expected %0d, got %0d", want.out_row, rsp_mon.out_row);
                  fail_count++;
               end
               if (rsp_mon.out_col !== want.out_col) begin
                  $error("out_col: expected %0d, got %0d", want.out_col, rsp_mon.out_col);
                  fail_count++;
               end
               if (rsp_mon.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame at (%0d,%0d): expected %0d, got %0d", want.out_row,
                         want.out_col, want.last_of_frame, rsp_mon.last_of_frame);
                  fail_count++;
               end
               if (rsp_mon.max_residual !== want.max_residual) begin
                  $error("max_residual at (%0d,%0d): expected %0d, got %0d", want.out_row,
                         want.out_col, want.max_residual, rsp_mon.max_residual);
                  fail_count++;
               end
            end
         end
      end
      pending = cell_queue.size();
   end

endmodule

FILE: test/heat_plate_stencil_sweep_test.sv
`timescale 1ns / 1ps
// Top of the stencil sweep testbench: clock, reset, request and configuration stimulus,
// response back-pressure and the verdict. Needs hpss_pkg, the channel interfaces,
// heat_plate_stencil_sweep and hpss_sweep_checker.
module heat_plate_stencil_sweep_test;
   import hpss_pkg::*;

   localparam int          HALF_PERIOD = 4;
   localparam int          HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum int {
      FILL_NOISE,
      FILL_FLAT,
      FILL_RIPPLE,
      FILL_PEAK,
      FILL_MAX,
      FILL_ZERO,
      FILL_SPIKE
   } fill_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        hold_ask = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          stall_tick = 0;
   int          burst_left = 0;
   int          requests_sent = 0;
   int unsigned cycle_count = 0;

   int fail_count, pending, rsp_count, sweep_count;

   hpss_req_if req_if ();
   hpss_rsp_if rsp_if ();
   hpss_csr_if csr_if ();

   heat_plate_stencil_sweep uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   hpss_sweep_checker sweep_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .fail_count  (fail_count),
      .pending     (pending),
      .rsp_count   (rsp_count),
      .sweep_count (sweep_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("heat_plate_stencil_sweep_test: errors");
         $finish;
      end
   end

   // Response back-pressure: rotating pattern, plus a long hold on request.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (stall_tick % 600 < 150) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_tick % 600 < 300) begin
         rsp_if.ready <= 1'($urandom_range(0, 1));
      end else if (stall_tick % 600 < 450) begin
         rsp_if.ready <= (stall_tick % 5 != 0);
      end else begin
         rsp_if.ready <= ($urandom_range(0, 3) == 0);
      end
   end

   function automatic int clamp_size(input logic [VAL_W-1:0] w);
      int v;
      v = w[SIZE_W-1:0];
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > MAX_SIZE) return MAX_SIZE;
      return v;
   endfunction

   function automatic logic [VAL_W-1:0] cell_for(input fill_kind_type kind, input int r,
                                                 input int c, input logic [VAL_W-1:0] base);
      logic [VAL_W-1:0] jitter;
      jitter = VAL_W'($urandom_range(0, 255));
      case (kind)
         FILL_NOISE:  return VAL_W'($urandom_range(0, 65535));
         FILL_FLAT:   return base + (jitter & 16'h000F);
         FILL_RIPPLE: return ((r + c) % 2 == 1) ? 16'hFFFF - jitter : jitter;
         FILL_PEAK:   return ($urandom_range(0, 7) == 0) ? (16'hFF00 | jitter) : jitter;
         FILL_MAX:    return 16'hFFFF;
         FILL_SPIKE:  return (r == 1 && c == 1) ? 16'hFFFF : 16'h0000;
         default:     return 16'h0000;
      endcase
   endfunction

   // Caller is at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cell(input logic [VAL_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.cell_value <= v;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [VAL_W-1:0] d);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= d;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   task automatic end_writes();
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_plate(input logic [VAL_W-1:0] rows, cols, prow, pcol, frow,
                            sbeg, send, hot);
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_POINT_ROW, prow);
      write_reg(REG_POINT_COL, pcol);
      write_reg(REG_FIXED_ROW, frow);
      write_reg(REG_SPAN_BEGIN, sbeg);
      write_reg(REG_SPAN_END, send);
      write_reg(REG_HOT_VALUE, hot);
      end_writes();
   endtask

   // Drop valid and hold until every predicted response is back.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_sweep(input fill_kind_type kind, input int nr, input int nc,
                            input logic [VAL_W-1:0] base, input int pause_at);
      int idx;
      idx = 0;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            if (idx == pause_at) begin
               req_if.valid <= 1'b0;
               @(negedge clock);
               while (pending != 0) @(negedge clock);
            end
            send_cell(cell_for(kind, r, c, base));
            idx++;
         end
      end
   endtask

   initial begin
      int rows_w, cols_w, nr, nc, random_sent, sweep_no;
      fill_kind_type kind;
      req_if.valid      = 1'b0;
      req_if.cell_value = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = REG_ROWS;
      csr_if.data       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset hot cells lie outside a 4 x 5 plate.
      write_reg(REG_ROWS, 16'd4);
      write_reg(REG_COLS, 16'd5);
      end_writes();
      run_sweep(FILL_NOISE, 4, 5, '0, -1);
      settle();

      set_plate(16'd3, 16'd3, 16'd1, 16'd1, 16'd5, 16'd0, 16'd0, 16'hFFFF);
      run_sweep(FILL_MAX, 3, 3, '0, -1);
      settle();

      // Clamped sizes, hot cells off the plate, inverted span, peak residual.
      set_plate(16'd0, 16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'h0000);
      run_sweep(FILL_SPIKE, 3, 3, '0, -1);
      settle();

      set_plate(16'd3, 16'd4, 16'd2, 16'd0, 16'd0, 16'd0, 16'd4, 16'h1234);
      run_sweep(FILL_ZERO, 3, 4, '0, -1);
      settle();

      random_sent = 0;
      sweep_no = 0;
      while (random_sent < 900) begin
         rows_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         cols_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
         if (sweep_no == 0) begin
            rows_w = 10;
            cols_w = 16;
         end
         nr = clamp_size(VAL_W'(rows_w));
         nc = clamp_size(VAL_W'(cols_w));
         set_plate(VAL_W'(rows_w), VAL_W'(cols_w),
                   VAL_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, nr - 1)
                                                      : $urandom_range(0, 8191)),
                   VAL_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, nc - 1)
                                                      : $urandom_range(0, 8191)),
                   VAL_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, nr - 1)
                                                      : $urandom_range(0, 8191)),
                   VAL_W'($urandom_range(0, nc)), VAL_W'($urandom_range(0, nc + 1)),
                   VAL_W'($urandom_range(0, 65535)));
         kind = fill_kind_type'($urandom_range(FILL_NOISE, FILL_PEAK));
         if (sweep_no == 0) hold_ask <= ~hold_ask;
         run_sweep(kind, nr, nc, VAL_W'($urandom_range(0, 65535)),
                   (sweep_no == 1) ? nr * nc / 2 : -1);
         settle();
         random_sent += nr * nc;
         sweep_no++;
      end

      $display("Sent %0d requests in %0d sweeps; %0d responses checked.",
               requests_sent, sweep_count, rsp_count);
      $display("Plates from 3x3 to 12x16 with hot cells, spans, clamps and a long hold.");
      if (fail_count == 0) begin
         $display("heat_plate_stencil_sweep_test: clean");
      end else begin
         $display("heat_plate_stencil_sweep_test: errors");
      end
      $finish;
   end

endmodule
